FILE: design/gom_pkg.sv
// Shared types and constants for the glob / substring matcher.
package gom_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int CHAR_BITS_DEF   = 16;

  // Register file layout
  localparam int REG_WORDS      = 4;
  localparam int CHARS_PER_WORD = 4;
  localparam int PAT_CHAR_W     = 16;
  localparam int REG_CHARS      = REG_WORDS * CHARS_PER_WORD;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int LEN_W          = 5;

  localparam logic [PAT_CHAR_W-1:0] SYM_STAR     = 16'h002A;
  localparam logic [PAT_CHAR_W-1:0] SYM_QUESTION = 16'h003F;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PATTERN_WORD_0 = 3'd0,
    REG_PATTERN_WORD_1 = 3'd1,
    REG_PATTERN_WORD_2 = 3'd2,
    REG_PATTERN_WORD_3 = 3'd3,
    REG_PATTERN_LENGTH = 3'd4,
    REG_SUBSTRING_MODE = 3'd5
  } gom_reg_t;

  // Per-transaction control fanned out to every cell
  typedef struct packed {
    logic sub;      // literal substring mode
    logic valid;    // transaction carries a character
    logic restart;  // end of text, return to start state
    logic enable;   // input transaction accepted
  } gom_cell_ctrl_t;

endpackage

FILE: design/gom_cell.sv
// One pattern position: holds the active bit for position i+1 and its transitions.
module gom_cell #(
  parameter int CHAR_BITS = gom_pkg::CHAR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  gom_pkg::gom_cell_ctrl_t ctrl,
  input  logic                  in_use,
  input  logic [CHAR_BITS-1:0]  pch,
  input  logic [CHAR_BITS-1:0]  ch,
  input  logic                  ca_in,
  input  logic                  nxc_in,
  input  logic                  stay_in,
  output logic                  act,
  output logic                  ca_out,
  output logic                  nxc_out,
  output logic                  stay_out
);

  logic is_star;
  logic is_q;
  logic eq;
  logic star_g;
  logic adv;
  logic nx_bit;

  assign is_star = (pch == gom_pkg::SYM_STAR[CHAR_BITS-1:0]);
  assign is_q    = (pch == gom_pkg::SYM_QUESTION[CHAR_BITS-1:0]);
  assign eq      = (pch == ch);

  // star only acts in glob mode
  assign star_g = in_use & ~ctrl.sub & is_star;

  // closure of the current set, rippling forward
  assign ca_out = act | (ca_in & star_g);

  always_comb begin
    if (ctrl.sub) begin
      adv = in_use & ca_in & eq;
    end else begin
      adv = in_use & ca_in & ~is_star & (is_q | eq);
    end
  end

  // a star keeps its own position live; handed back to the previous cell
  assign stay_out = star_g & ca_in;

  assign nx_bit  = adv | stay_in;
  assign nxc_out = nx_bit | (nxc_in & star_g);

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
    end else if (ctrl.enable) begin
      if (ctrl.restart) begin
        act <= 1'b0;
      end else if (ctrl.valid) begin
        act <= nxc_out;
      end
    end
  end

endmodule

FILE: design/gom_out_buf.sv
// Result register with a skid stage so the input side keeps flowing.
module gom_out_buf (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic din,
  input  logic out_ready,
  output logic out_valid,
  output logic dout,
  output logic in_ready
);

  logic skid_valid;
  logic skid_data;

  assign in_ready = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (~out_valid | out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (~out_valid | out_ready) begin
      if (skid_valid) begin
        dout      <= skid_data;
        skid_data <= din;
      end else begin
        dout <= din;
      end
    end else if (push) begin
      skid_data <= din;
    end
  end

endmodule

FILE: design/glob_or_substring_matcher.sv
// Top level of the glob / substring matcher: config registers, cell chain, result buffer.
//
// Input stream s_axis carries one text character per transaction (tdata), tuser
// says whether the character is present, tlast ends the text. Only a transaction
// with tlast produces a result: one byte on m_axis, bit 0 set when the text
// matched the pattern held in the config registers.
// Config is written through cfg_we / cfg_addr / cfg_wdata, one register per cycle;
// the user must write it only while no text is in flight; the block does not enforce it.
// Throughput is one character per cycle while s_axis_tready is high. The result of a
// text is registered into the buffer driving m_axis when its tlast transaction is
// accepted. Cycle time is set by the star closure, which ripples through the row of
// cells twice per character. If the receiver stalls, one result waits on m_axis and
// a second in a skid register; s_axis_tready drops only while both are full. Until
// then every transaction keeps being accepted.
// Reset clears the pattern, length and mode to zero, returns the match state to
// the start position and empties the output buffer.
module glob_or_substring_matcher #(
  parameter int PATTERN_MAX = gom_pkg::PATTERN_MAX_DEF,
  parameter int CHAR_BITS   = gom_pkg::CHAR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,   // [15:0] ch
  input  logic                            s_axis_tuser,   // [0] char_valid
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,   // [0] matched
  input  logic                            cfg_we,
  input  logic [gom_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [gom_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int NW = $clog2(PATTERN_MAX + 1);

  logic [gom_pkg::CFG_DATA_W-1:0] pattern_word [gom_pkg::REG_WORDS];
  logic [gom_pkg::LEN_W-1:0]      pattern_length;
  logic                           substring_mode;

  logic                    act0;
  logic                    found;
  logic                    accept;
  logic [NW-1:0]           n_eff;
  logic [5:0]              len_ext;
  logic [PATTERN_MAX:0]    act;
  logic [PATTERN_MAX:0]    ca;
  logic [PATTERN_MAX:0]    nxc;
  logic [PATTERN_MAX:0]    stay;
  logic [PATTERN_MAX-1:0]  in_use;
  logic [CHAR_BITS-1:0]    ch;
  logic                    result;
  logic                    matched;
  gom_pkg::gom_cell_ctrl_t ctrl;

  // ---------------- config registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < gom_pkg::REG_WORDS; w++) begin
        pattern_word[w] <= '0;
      end
      pattern_length <= '0;
      substring_mode <= 1'b0;
    end else if (cfg_we) begin
      case (gom_pkg::gom_reg_t'(cfg_addr))
        gom_pkg::REG_PATTERN_WORD_0: pattern_word[0] <= cfg_wdata;
        gom_pkg::REG_PATTERN_WORD_1: pattern_word[1] <= cfg_wdata;
        gom_pkg::REG_PATTERN_WORD_2: pattern_word[2] <= cfg_wdata;
        gom_pkg::REG_PATTERN_WORD_3: pattern_word[3] <= cfg_wdata;
        gom_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_wdata[gom_pkg::LEN_W-1:0];
        gom_pkg::REG_SUBSTRING_MODE: substring_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // length saturates at the number of cells
  assign len_ext = {1'b0, pattern_length};
  assign n_eff   = (len_ext > 6'(PATTERN_MAX)) ? NW'(PATTERN_MAX) : NW'(len_ext);

  assign accept = s_axis_tvalid & s_axis_tready;
  assign ch     = s_axis_tdata[CHAR_BITS-1:0];

  assign ctrl.sub     = substring_mode;
  assign ctrl.valid   = s_axis_tuser;
  assign ctrl.restart = s_axis_tlast;
  assign ctrl.enable  = accept;

  // ---------------- position 0 ----------------
  assign act[0]            = act0;
  assign ca[0]             = act0 | substring_mode;
  assign nxc[0]            = substring_mode | stay[0];
  assign stay[PATTERN_MAX] = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      act0  <= 1'b1;
      found <= 1'b0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        act0  <= 1'b1;
        found <= 1'b0;
      end else if (s_axis_tuser) begin
        act0 <= nxc[0];
        if (substring_mode && ((n_eff == '0) || nxc[n_eff])) begin
          found <= 1'b1;
        end
      end
    end
  end

  // ---------------- row of cells ----------------
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic [CHAR_BITS-1:0] pch;

    if (i < gom_pkg::REG_CHARS) begin : g_reg
      assign pch = pattern_word[i / gom_pkg::CHARS_PER_WORD]
                   [(i % gom_pkg::CHARS_PER_WORD) * gom_pkg::PAT_CHAR_W +: CHAR_BITS];
    end else begin : g_zero
      assign pch = '0;
    end

    assign in_use[i] = (NW'(i) < n_eff);

    gom_cell #(
      .CHAR_BITS (CHAR_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .in_use   (in_use[i]),
      .pch      (pch),
      .ch       (ch),
      .ca_in    (ca[i]),
      .nxc_in   (nxc[i]),
      .stay_in  (stay[i+1]),
      .act      (act[i+1]),
      .ca_out   (ca[i+1]),
      .nxc_out  (nxc[i+1]),
      .stay_out (stay[i])
    );
  end

  // ---------------- result ----------------
  always_comb begin
    if (substring_mode) begin
      result = found | (n_eff == '0) | (s_axis_tuser ? nxc[n_eff] : act[n_eff]);
    end else begin
      result = s_axis_tuser ? nxc[n_eff] : ca[n_eff];
    end
  end

  gom_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept & s_axis_tlast),
    .din       (result),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .dout      (matched),
    .in_ready  (s_axis_tready)
  );

  assign m_axis_tdata = {7'b0, matched};

endmodule

FILE: design/gom_checker.sv
// Port-level checks for the matcher, bound to the top level.
module gom_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // output buffer is empty straight after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result pending right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // end of text with an empty output gives a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast && !m_axis_tvalid |=> m_axis_tvalid)
    else $error("end of text without a result");

  // input only stalls behind a pending result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[7:1] == 7'b0)
    else $error("result padding not zero");

endmodule

bind glob_or_substring_matcher gom_checker u_gom_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: sim/testbench.sv
// Self-checking testbench for glob_or_substring_matcher: directed and random texts.
`timescale 1ns / 100ps

module testbench;

  typedef logic [15:0] text_t[$];

  localparam int ITEM_TARGET = 1350;
  localparam logic [15:0] CH_A = 16'h0061;
  localparam logic [15:0] CH_B = 16'h0062;
  localparam logic [15:0] CH_C = 16'h0063;

  // Shadow of the matcher: registers, position set and found flag.
  class match_scoreboard;
    logic [gom_pkg::CFG_DATA_W-1:0] pat_word [gom_pkg::REG_WORDS];
    logic [gom_pkg::LEN_W-1:0] pat_len;
    bit sub_mode;
    logic [gom_pkg::PATTERN_MAX_DEF:0] active;
    bit found;
    bit matches_due[$];
    int errors;

    function new();
      foreach (pat_word[k]) pat_word[k] = '0;
      pat_len = '0;
      sub_mode = 1'b0;
      active = (gom_pkg::PATTERN_MAX_DEF + 1)'(1);
      found = 1'b0;
      errors = 0;
    endfunction

    function void load_reg(gom_pkg::gom_reg_t idx, logic [gom_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        gom_pkg::REG_PATTERN_WORD_0, gom_pkg::REG_PATTERN_WORD_1,
        gom_pkg::REG_PATTERN_WORD_2, gom_pkg::REG_PATTERN_WORD_3: pat_word[int'(idx)] = d;
        gom_pkg::REG_PATTERN_LENGTH: pat_len = d[gom_pkg::LEN_W-1:0];
        gom_pkg::REG_SUBSTRING_MODE: sub_mode = d[0];
        default: ;
      endcase
    endfunction

    function logic [gom_pkg::PAT_CHAR_W-1:0] pat_char(int i);
      if (i >= gom_pkg::REG_CHARS) return '0;
      return pat_word[i / gom_pkg::CHARS_PER_WORD]
                     [(i % gom_pkg::CHARS_PER_WORD) * gom_pkg::PAT_CHAR_W
                      +: gom_pkg::PAT_CHAR_W];
    endfunction

    function int eff_len();
      return (int'(pat_len) > gom_pkg::PATTERN_MAX_DEF) ? gom_pkg::PATTERN_MAX_DEF
                                                        : int'(pat_len);
    endfunction

    // a star lets its position through to the next one, rippling along the row
    function logic [gom_pkg::PATTERN_MAX_DEF:0] star_close(
        logic [gom_pkg::PATTERN_MAX_DEF:0] a, int n);
      for (int i = 0; i < n; i++)
        if (a[i] && pat_char(i) == gom_pkg::SYM_STAR) a[i+1] = 1'b1;
      return a;
    endfunction

    function void consume(logic [15:0] c);
      int n;
      logic [gom_pkg::PATTERN_MAX_DEF:0] a;
      logic [gom_pkg::PATTERN_MAX_DEF:0] nxt;
      logic [gom_pkg::PAT_CHAR_W-1:0] p;
      n = eff_len();
      a = active;
      nxt = '0;
      if (sub_mode) begin
        a[0] = 1'b1;
        for (int i = 0; i < n; i++)
          if (a[i] && pat_char(i) == c) nxt[i+1] = 1'b1;
        nxt[0] = 1'b1;
        if (n == 0 || nxt[n]) found = 1'b1;
      end else begin
        a = star_close(a, n);
        for (int i = 0; i < n; i++) begin
          if (a[i]) begin
            p = pat_char(i);
            if (p == gom_pkg::SYM_STAR) nxt[i] = 1'b1;
            else if (p == gom_pkg::SYM_QUESTION || p == c) nxt[i+1] = 1'b1;
          end
        end
        nxt = star_close(nxt, n);
      end
      active = nxt;
    endfunction

    function bit text_outcome();
      int n;
      logic [gom_pkg::PATTERN_MAX_DEF:0] a;
      n = eff_len();
      if (sub_mode) return found || n == 0 || active[n];
      a = star_close(active, n);
      return a[n];
    endfunction

    function void note_input(logic [15:0] ch, bit valid, bit last);
      if (valid) consume(ch);
      if (last) begin
        matches_due.insert(matches_due.size(), text_outcome());
        active = (gom_pkg::PATTERN_MAX_DEF + 1)'(1);
        found = 1'b0;
      end
    endfunction

    function void check_result(logic [7:0] got);
      logic [7:0] want;
      if (matches_due.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %02h", $time, got);
        errors++;
        return;
      end
      want = {7'b0, matches_due.pop_front()};
      if (got !== want) begin
        $display("%0t: matched wrong, expected %02h actual %02h", $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return matches_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [gom_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [gom_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  match_scoreboard sb = new();
  text_t cur_pat;
  bit cur_mode;
  bit src_steady;
  bit sink_steady;
  int sent_items;

  glob_or_substring_matcher dut (.*);

  always #5 clk = ~clk;

  initial begin
    #5000000;
    $display("glob_or_substring_matcher regression: fail");
    $finish;
  end

  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

  // result side: random hold-off before each transaction, with steady stretches
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 4) == 0) sink_steady = !sink_steady;
      gap = sink_steady ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  task automatic send_item(input logic [15:0] ch, input bit valid, input bit last);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ch;
    s_axis_tuser <= valid;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(ch, valid, last);
    sent_items++;
  endtask

  task automatic cfg_write(input gom_pkg::gom_reg_t idx,
                           input logic [gom_pkg::CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    sb.load_reg(idx, d);
  endtask

  // unused pattern slots get random junk
  task automatic configure(input bit mode, input logic [gom_pkg::LEN_W-1:0] len,
                           input text_t pat);
    logic [gom_pkg::CFG_DATA_W-1:0] w [gom_pkg::REG_WORDS];
    foreach (w[k]) w[k] = {$urandom, $urandom};
    foreach (pat[i])
      w[i / gom_pkg::CHARS_PER_WORD]
       [(i % gom_pkg::CHARS_PER_WORD) * gom_pkg::PAT_CHAR_W +: gom_pkg::PAT_CHAR_W] = pat[i];
    cfg_write(gom_pkg::REG_PATTERN_WORD_0, w[0]);
    cfg_write(gom_pkg::REG_PATTERN_WORD_1, w[1]);
    cfg_write(gom_pkg::REG_PATTERN_WORD_2, w[2]);
    cfg_write(gom_pkg::REG_PATTERN_WORD_3, w[3]);
    cfg_write(gom_pkg::REG_PATTERN_LENGTH, gom_pkg::CFG_DATA_W'(len));
    cfg_write(gom_pkg::REG_SUBSTRING_MODE, gom_pkg::CFG_DATA_W'(mode));
    cfg_we <= 1'b0;
    cur_pat = pat;
    cur_mode = mode;
  endtask

  // drain outstanding results before touching the registers
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return CH_A + 16'($urandom_range(0, 2));
      4: return gom_pkg::SYM_STAR;
      5: return gom_pkg::SYM_QUESTION;
      6, 7: if (cur_pat.size() > 0) return cur_pat[$urandom_range(0, cur_pat.size() - 1)];
      default: ;
    endcase
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_pattern_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return CH_A + 16'($urandom_range(0, 2));
      5, 6: return gom_pkg::SYM_STAR;
      7: return gom_pkg::SYM_QUESTION;
      8: return 16'($urandom);
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  task automatic random_config(input int phase);
    logic [gom_pkg::LEN_W-1:0] len;
    bit mode;
    int n;
    text_t pat;
    mode = $urandom_range(0, 1);
    case (phase % 8)
      0: len = '0;
      1: len = '1;
      2: len = gom_pkg::LEN_W'(gom_pkg::PATTERN_MAX_DEF);
      3: len = gom_pkg::LEN_W'($urandom_range(gom_pkg::PATTERN_MAX_DEF + 1, 30));
      default: len = gom_pkg::LEN_W'($urandom_range(1, 8));
    endcase
    n = (int'(len) > gom_pkg::PATTERN_MAX_DEF) ? gom_pkg::PATTERN_MAX_DEF : int'(len);
    repeat (n) pat.insert(pat.size(), pick_pattern_char());
    configure(mode, len, pat);
  endtask

  // mostly texts built to match, some with one edit, the rest noise
  task automatic build_text(output text_t t);
    int kind;
    int idx;
    t = {};
    kind = $urandom_range(0, 7);
    if (kind < 5) begin
      if (cur_mode) begin
        repeat ($urandom_range(0, 4)) t.insert(t.size(), pick_char());
        foreach (cur_pat[i]) t.insert(t.size(), cur_pat[i]);
        repeat ($urandom_range(0, 4)) t.insert(t.size(), pick_char());
      end else begin
        foreach (cur_pat[i])
          if (cur_pat[i] == gom_pkg::SYM_STAR)
            repeat ($urandom_range(0, 3)) t.insert(t.size(), pick_char());
          else if (cur_pat[i] == gom_pkg::SYM_QUESTION) t.insert(t.size(), pick_char());
          else t.insert(t.size(), cur_pat[i]);
      end
      if (kind >= 3 && t.size() > 0) begin
        idx = $urandom_range(0, t.size() - 1);
        case ($urandom_range(0, 2))
          0: t.delete(idx);
          1: t.insert(idx, pick_char());
          default: t[idx] = pick_char();
        endcase
      end
    end else begin
      repeat ($urandom_range(0, 12)) t.insert(t.size(), 16'($urandom));
    end
  endtask

  task automatic send_text(input text_t t);
    bit marker;
    if ($urandom_range(0, 4) == 0) src_steady = !src_steady;
    marker = (t.size() == 0) || ($urandom_range(0, 2) == 0);
    foreach (t[i]) begin
      if ($urandom_range(0, 7) == 0) send_item(16'($urandom), 1'b0, 1'b0);
      send_item(t[i], 1'b1, !marker && i == t.size() - 1);
    end
    if (marker) send_item(16'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int phase;
    text_t t;
    text_t dir_pat;
    text_t none;
    phase = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty glob pattern: only the empty text matches
    settle();
    configure(1'b0, '0, none);
    send_item(16'h0000, 1'b0, 1'b1);
    send_item(16'hFFFF, 1'b1, 1'b1);

    // empty substring pattern always matches
    settle();
    configure(1'b1, '0, none);
    send_item(16'h8000, 1'b1, 1'b1);
    send_item(16'h0000, 1'b0, 1'b1);

    // full-width glob, oversized length saturates
    settle();
    dir_pat = {gom_pkg::SYM_STAR, gom_pkg::SYM_QUESTION, CH_A, 16'hFFFF, 16'h0000,
               gom_pkg::SYM_STAR, gom_pkg::SYM_STAR, CH_B, gom_pkg::SYM_QUESTION,
               gom_pkg::SYM_STAR, CH_C, gom_pkg::SYM_STAR, gom_pkg::SYM_QUESTION,
               16'h8001, 16'h7FFE, gom_pkg::SYM_STAR};
    configure(1'b0, '1, dir_pat);
    send_item(16'h007A, 1'b1, 1'b0);
    send_item(16'hABCD, 1'b0, 1'b0);
    send_item(CH_A, 1'b1, 1'b0);
    send_item(16'hFFFF, 1'b1, 1'b0);
    send_item(16'h0000, 1'b1, 1'b0);
    send_item(16'h0071, 1'b1, 1'b0);
    send_item(CH_B, 1'b1, 1'b0);
    send_item(gom_pkg::SYM_STAR, 1'b1, 1'b0);
    send_item(CH_C, 1'b1, 1'b0);
    send_item(16'h5555, 1'b1, 1'b0);
    send_item(16'h8001, 1'b1, 1'b0);
    send_item(16'h7FFE, 1'b1, 1'b1);

    // wildcards are literals in substring mode
    settle();
    dir_pat = {gom_pkg::SYM_STAR, gom_pkg::SYM_QUESTION, CH_A};
    configure(1'b1, 5'd3, dir_pat);
    send_item(16'h0078, 1'b1, 1'b0);
    send_item(gom_pkg::SYM_STAR, 1'b1, 1'b0);
    send_item(gom_pkg::SYM_QUESTION, 1'b1, 1'b0);
    send_item(CH_A, 1'b1, 1'b1);

    while (sent_items < ITEM_TARGET) begin
      settle();
      random_config(phase);
      phase++;
      repeat (8) begin
        build_text(t);
        send_text(t);
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("glob_or_substring_matcher regression: pass");
    else
      $display("glob_or_substring_matcher regression: fail");
    $finish;
  end

endmodule
